[hw/rtl/lpds_pkg.sv]
// Package: shared types and constants of the layer priority draw sequencer
package lpds_pkg;

   // Command kinds on the result channel
   localparam logic [1:0] KIND_SPRITE = 2'd0;
   localparam logic [1:0] KIND_LAYER  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] REG_SCROLL1_MASK = 2'd0;
   localparam logic [1:0] REG_SCROLL2_MASK = 2'd1;
   localparam logic [1:0] REG_SCROLL3_MASK = 2'd2;
   localparam logic [1:0] REG_USER_MASK    = 2'd3;

   // Slot code of a discarded duplicate layer
   localparam logic [2:0] SLOT_GONE = 3'd4;

   // Reset value of the user layer mask
   localparam logic [3:0] USER_MASK_RESET = 4'hF;

   // Highest sprite priority
   localparam logic [2:0] PRIO_TOP = 3'd7;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SPRITE,
      ST_LAYER,
      ST_TAIL,
      ST_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic store;
      logic advance;
      logic emit_sprite;
      logic emit_layer;
      logic emit_tail;
      logic emit_done;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_sprite;
      logic need_layer;
      logic walk_end;
      logic tail_needed;
      logic out_free;
   } status_type;

endpackage

[hw/rtl/lpds_channels.sv]
// Interfaces: slice input, command output and register write channels
interface lpds_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] layer_control;
   logic [15:0] layer_priority;
   logic [7:0]  slice_start_line;
   logic        last_slice;

   modport source (output valid, layer_control, layer_priority, slice_start_line,
                   last_slice, input ready);
   modport sink (input valid, layer_control, layer_priority, slice_start_line,
                 last_slice, output ready);
endinterface

interface lpds_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] command_kind;
   logic [1:0] layer_number;
   logic [3:0] slice_number;
   logic [7:0] span_first_line;
   logic [7:0] span_end_line;
   logic [2:0] sprite_prio_low;
   logic [2:0] sprite_prio_high;
   logic       run_last;

   modport source (output valid, command_kind, layer_number, slice_number,
                   span_first_line, span_end_line, sprite_prio_low,
                   sprite_prio_high, run_last, input ready);
   modport sink (input valid, command_kind, layer_number, slice_number,
                 span_first_line, span_end_line, sprite_prio_low,
                 sprite_prio_high, run_last, output ready);
endinterface

interface lpds_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/lpds_ctrl.sv]
// Controller: sequences slice loading and the priority walk
module lpds_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last_slice,
   output logic                   req_ready,
   input  lpds_pkg::status_type   status,
   output lpds_pkg::cmd_type      cmd
);

   lpds_pkg::state_type state_ff;
   lpds_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpds_pkg::ST_IDLE: begin
            if (req_valid && req_last_slice) state_in = lpds_pkg::ST_SCAN;
         end
         lpds_pkg::ST_SCAN: begin
            if (status.need_sprite) state_in = lpds_pkg::ST_SPRITE;
            else if (status.need_layer) state_in = lpds_pkg::ST_LAYER;
            else if (status.walk_end) state_in = lpds_pkg::ST_TAIL;
         end
         lpds_pkg::ST_SPRITE: begin
            if (status.out_free) begin
               if (status.need_layer) state_in = lpds_pkg::ST_LAYER;
               else if (status.walk_end) state_in = lpds_pkg::ST_TAIL;
               else state_in = lpds_pkg::ST_SCAN;
            end
         end
         lpds_pkg::ST_LAYER: begin
            if (status.out_free) begin
               state_in = status.walk_end ? lpds_pkg::ST_TAIL : lpds_pkg::ST_SCAN;
            end
         end
         lpds_pkg::ST_TAIL: begin
            if (!status.tail_needed || status.out_free) state_in = lpds_pkg::ST_DONE;
         end
         lpds_pkg::ST_DONE: begin
            if (status.out_free) state_in = lpds_pkg::ST_IDLE;
         end
         default: state_in = lpds_pkg::ST_IDLE;
      endcase
   end

   // Commands and handshake
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         lpds_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.store = req_valid;
         end
         lpds_pkg::ST_SCAN: begin
            cmd.advance = !status.need_sprite && !status.need_layer;
         end
         lpds_pkg::ST_SPRITE: begin
            cmd.emit_sprite = status.out_free;
            cmd.advance     = status.out_free && !status.need_layer;
         end
         lpds_pkg::ST_LAYER: begin
            cmd.emit_layer = status.out_free;
            cmd.advance    = status.out_free;
         end
         lpds_pkg::ST_TAIL: begin
            cmd.emit_tail = status.out_free && status.tail_needed;
         end
         lpds_pkg::ST_DONE: begin
            cmd.emit_done = status.out_free;
         end
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[hw/rtl/lpds_datapath.sv]
// Datapath: slice decode and storage, walk counters and result register
module lpds_datapath #(
   parameter int SLICE_SLOTS  = 8,
   parameter int SCREEN_LINES = 224
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lpds_pkg::cmd_type    cmd,
   output lpds_pkg::status_type status,
   input  logic [15:0]          req_layer_control,
   input  logic [15:0]          req_layer_priority,
   input  logic [7:0]           req_slice_start_line,
   input  logic                 csr_valid,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_command_kind,
   output logic [1:0]           rsp_layer_number,
   output logic [3:0]           rsp_slice_number,
   output logic [7:0]           rsp_span_first_line,
   output logic [7:0]           rsp_span_end_line,
   output logic [2:0]           rsp_sprite_prio_low,
   output logic [2:0]           rsp_sprite_prio_high,
   output logic                 rsp_run_last
);

   localparam int IDX_W = (SLICE_SLOTS > 1) ? $clog2(SLICE_SLOTS) : 1;
   localparam int CNT_W = $clog2(SLICE_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_FULL  = CNT_W'(SLICE_SLOTS);
   localparam logic [7:0]       LINES_END   = 8'(SCREEN_LINES);

   // Configuration registers
   logic [15:0] mask1_ff, mask2_ff, mask3_ff;
   logic [3:0]  user_mask_ff;

   // Slice store
   logic [11:0] order_ff [SLICE_SLOTS];
   logic [8:0]  prio_ff  [SLICE_SLOTS];
   logic [3:0]  en_ff    [SLICE_SLOTS];
   logic [7:0]  lines_ff [SLICE_SLOTS];
   logic [7:0]  ends_ff  [SLICE_SLOTS];
   logic [CNT_W-1:0] count_ff;

   // Walk counters
   logic [2:0]       p_ff;
   logic [IDX_W-1:0] s_ff;
   logic [1:0]       i_ff;
   logic [3:0]       next_low_ff;

   // Result register
   logic       rsp_valid_ff;
   logic [1:0] kind_ff, layer_ff;
   logic [3:0] slice_ff;
   logic [7:0] first_ff, end_ff;
   logic [2:0] low_ff, high_ff;
   logic       last_ff;

   // Decode signals
   logic [1:0]  slot [4];
   logic        gone [4];
   logic [2:0]  pr   [4];
   logic [2:0]  high_v;
   logic        high_set;
   logic [11:0] order_new;
   logic [8:0]  prio_new;
   logic [3:0]  en_new;
   logic [7:0]  end_new;
   logic [CNT_W-1:0] prev_cnt;

   // Walk signals
   logic [11:0]      cur_order;
   logic [8:0]       cur_prio;
   logic [3:0]       cur_en;
   logic [2:0]       cur_layer;
   logic [2:0]       cur_lp;
   logic [CNT_W-1:0] s_next;
   logic             s_last;
   logic             match;
   logic             sprites;
   logic [7:0]       cur_end;

   // Decode the incoming slice: drop lower duplicates, clamp priorities
   always_comb begin
      slot[3] = req_layer_control[13:12];
      slot[2] = req_layer_control[11:10];
      slot[1] = req_layer_control[9:8];
      slot[0] = req_layer_control[7:6];
      gone[3] = 1'b0;
      gone[2] = (slot[3] == slot[2]);
      gone[1] = (!gone[3] && slot[3] == slot[1]) || (!gone[2] && slot[2] == slot[1]);
      gone[0] = (!gone[3] && slot[3] == slot[0]) || (!gone[2] && slot[2] == slot[0])
                || (!gone[1] && slot[1] == slot[0]);
      pr[0] = 3'd0;
      pr[1] = req_layer_priority[6:4];
      pr[2] = req_layer_priority[10:8];
      pr[3] = req_layer_priority[14:12];
      high_v   = 3'd0;
      high_set = 1'b0;
      for (int j = 3; j >= 0; j--) begin
         if (!gone[j] && slot[j] != 2'd0) begin
            if (high_set && pr[slot[j]] > high_v) begin
               pr[slot[j]] = high_v;
            end else begin
               high_v   = pr[slot[j]];
               high_set = 1'b1;
            end
         end
      end
      for (int j = 0; j < 4; j++) begin
         order_new[3*j +: 3] = gone[j] ? lpds_pkg::SLOT_GONE : {1'b0, slot[j]};
      end
      prio_new = {pr[3], pr[2], pr[1]};
      en_new   = {|(req_layer_control & mask3_ff), |(req_layer_control & mask2_ff),
                  |(req_layer_control & mask1_ff), 1'b1} & user_mask_ff;
      end_new  = (req_slice_start_line != 8'd0) ? req_slice_start_line : LINES_END;
   end

   assign prev_cnt = count_ff - CNT_W'(1);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mask1_ff     <= '0;
         mask2_ff     <= '0;
         mask3_ff     <= '0;
         user_mask_ff <= lpds_pkg::USER_MASK_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            lpds_pkg::REG_SCROLL1_MASK: mask1_ff <= csr_data;
            lpds_pkg::REG_SCROLL2_MASK: mask2_ff <= csr_data;
            lpds_pkg::REG_SCROLL3_MASK: mask3_ff <= csr_data;
            lpds_pkg::REG_USER_MASK:    user_mask_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Store a slice; close the span of the one before it
   always_ff @(posedge clock) begin
      if (cmd.store && count_ff < SLOTS_FULL) begin
         order_ff[count_ff[IDX_W-1:0]] <= order_new;
         prio_ff[count_ff[IDX_W-1:0]]  <= prio_new;
         en_ff[count_ff[IDX_W-1:0]]    <= en_new;
         lines_ff[count_ff[IDX_W-1:0]] <= req_slice_start_line;
         if (count_ff != '0) ends_ff[prev_cnt[IDX_W-1:0]] <= end_new;
      end
   end

   // Slice count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.emit_done) begin
         count_ff <= '0;
      end else if (cmd.store && count_ff < SLOTS_FULL) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // Read the slot under the walk counters
   always_comb begin
      cur_order = order_ff[s_ff];
      cur_prio  = prio_ff[s_ff];
      cur_en    = en_ff[s_ff];
      case (i_ff)
         2'd0:    cur_layer = cur_order[2:0];
         2'd1:    cur_layer = cur_order[5:3];
         2'd2:    cur_layer = cur_order[8:6];
         default: cur_layer = cur_order[11:9];
      endcase
      case (cur_layer)
         3'd1:    cur_lp = cur_prio[2:0];
         3'd2:    cur_lp = cur_prio[5:3];
         3'd3:    cur_lp = cur_prio[8:6];
         default: cur_lp = 3'd0;
      endcase
      s_next  = CNT_W'(s_ff) + CNT_W'(1);
      s_last  = (s_next == count_ff);
      cur_end = (s_next < count_ff) ? ends_ff[s_ff] : LINES_END;
      match   = !cur_layer[2] && (cur_lp == p_ff);
      sprites = en_ff[0][0];
   end

   // Status to the controller
   always_comb begin
      status.need_sprite = match && sprites && (next_low_ff <= {1'b0, p_ff});
      status.need_layer  = match && (cur_layer != 3'd0) && cur_en[cur_layer[1:0]];
      status.walk_end    = (p_ff == lpds_pkg::PRIO_TOP) && (i_ff == 2'd3) && s_last;
      status.tail_needed = sprites && (next_low_ff <= {1'b0, lpds_pkg::PRIO_TOP});
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Advance slot, slice and priority counters
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= '0;
         s_ff <= '0;
         i_ff <= '0;
      end else if (cmd.advance) begin
         i_ff <= i_ff + 2'd1;
         if (i_ff == 2'd3) begin
            if (s_last) begin
               s_ff <= '0;
               p_ff <= p_ff + 3'd1;
            end else begin
               s_ff <= s_ff + IDX_W'(1);
            end
         end
      end
   end

   // Lowest sprite priority not yet covered
   always_ff @(posedge clock) begin
      if (reset) begin
         next_low_ff <= '0;
      end else if (cmd.emit_done) begin
         next_low_ff <= '0;
      end else if (cmd.emit_sprite) begin
         next_low_ff <= {1'b0, p_ff} + 4'd1;
      end
   end

   // Result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_sprite || cmd.emit_layer || cmd.emit_tail || cmd.emit_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.emit_sprite || cmd.emit_tail) begin
         kind_ff  <= lpds_pkg::KIND_SPRITE;
         layer_ff <= '0;
         slice_ff <= '0;
         first_ff <= '0;
         end_ff   <= '0;
         low_ff   <= next_low_ff[2:0];
         high_ff  <= cmd.emit_sprite ? p_ff : lpds_pkg::PRIO_TOP;
         last_ff  <= 1'b0;
      end else if (cmd.emit_layer) begin
         kind_ff  <= lpds_pkg::KIND_LAYER;
         layer_ff <= cur_layer[1:0];
         slice_ff <= 4'(s_ff);
         first_ff <= lines_ff[s_ff];
         end_ff   <= cur_end;
         low_ff   <= '0;
         high_ff  <= '0;
         last_ff  <= 1'b0;
      end else if (cmd.emit_done) begin
         kind_ff  <= lpds_pkg::KIND_DONE;
         layer_ff <= '0;
         slice_ff <= '0;
         first_ff <= '0;
         end_ff   <= '0;
         low_ff   <= '0;
         high_ff  <= '0;
         last_ff  <= 1'b1;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_command_kind     = kind_ff;
   assign rsp_layer_number     = layer_ff;
   assign rsp_slice_number     = slice_ff;
   assign rsp_span_first_line  = first_ff;
   assign rsp_span_end_line    = end_ff;
   assign rsp_sprite_prio_low  = low_ff;
   assign rsp_sprite_prio_high = high_ff;
   assign rsp_run_last         = last_ff;

endmodule

[hw/rtl/layer_priority_draw_sequencer_core.sv]
// Top level: layer priority draw sequencer, controller plus datapath
//
//   channel  direction  carries
//   req_bus  in         one screen slice: control word, priority word, start line
//   rsp_bus  out        sprite range, layer span or done command
//   csr_bus  in         write of register 0..3 (scroll masks, user mask)
//
// A slice that is not the last is stored while the block is idle. The last slice
// starts a walk over 8 priorities x stored slices x 4 slots, one slot per cycle while
// no command is issued, and ends with a closing sprite range, where one is needed, and
// a done item. Reset is synchronous; no clearing pass, the slice store is only read
// where written. A stalled result holds the walk; the next frame's slices are taken
// while the done item still waits in the result register.
module layer_priority_draw_sequencer_core #(
   parameter int SLICE_SLOTS  = 8,
   parameter int SCREEN_LINES = 224
) (
   input logic        clock,
   input logic        reset,
   lpds_req_if.sink   req_bus,
   lpds_rsp_if.source rsp_bus,
   lpds_csr_if.sink   csr_bus
);

   lpds_pkg::cmd_type    cmd;
   lpds_pkg::status_type status;
   logic                 req_ready;

   // Sequence control
   lpds_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_last_slice (req_bus.last_slice),
      .req_ready      (req_ready),
      .status         (status),
      .cmd            (cmd)
   );

   // Storage, walk and result register
   lpds_datapath #(
      .SLICE_SLOTS  (SLICE_SLOTS),
      .SCREEN_LINES (SCREEN_LINES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_layer_control    (req_bus.layer_control),
      .req_layer_priority   (req_bus.layer_priority),
      .req_slice_start_line (req_bus.slice_start_line),
      .csr_valid            (csr_bus.valid),
      .csr_index            (csr_bus.index),
      .csr_data             (csr_bus.data),
      .rsp_ready            (rsp_bus.ready),
      .rsp_valid            (rsp_bus.valid),
      .rsp_command_kind     (rsp_bus.command_kind),
      .rsp_layer_number     (rsp_bus.layer_number),
      .rsp_slice_number     (rsp_bus.slice_number),
      .rsp_span_first_line  (rsp_bus.span_first_line),
      .rsp_span_end_line    (rsp_bus.span_end_line),
      .rsp_sprite_prio_low  (rsp_bus.sprite_prio_low),
      .rsp_sprite_prio_high (rsp_bus.sprite_prio_high),
      .rsp_run_last         (rsp_bus.run_last)
   );

   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

endmodule

[hw/rtl/lpds_checker.sv]
// Checker: port-level properties of the draw sequencer, bound to the top level
module lpds_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_slice,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_command_kind,
   input logic [1:0] rsp_layer_number,
   input logic [3:0] rsp_slice_number,
   input logic [7:0] rsp_span_first_line,
   input logic [7:0] rsp_span_end_line,
   input logic [2:0] rsp_sprite_prio_low,
   input logic [2:0] rsp_sprite_prio_high,
   input logic       rsp_run_last
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_command_kind)
                                  && $stable(rsp_run_last))
      else $error("result dropped or changed while stalled");

   // Stop taking slices once the last slice of a frame is in
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_slice |=> !req_ready)
      else $error("slice transaction taken during the priority walk");

   // Done item carries nothing else
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_run_last |-> rsp_command_kind == lpds_pkg::KIND_DONE
         && rsp_layer_number == 2'd0 && rsp_slice_number == 4'd0
         && rsp_sprite_prio_low == 3'd0 && rsp_sprite_prio_high == 3'd0)
      else $error("malformed done transaction");

   // Sprite range is ordered
   a_sprite_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_kind == lpds_pkg::KIND_SPRITE
         |-> rsp_sprite_prio_low <= rsp_sprite_prio_high && !rsp_run_last)
      else $error("sprite range inverted");

   // Layer command names a scroll layer, a closed span and no sprite range
   a_layer_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_command_kind == lpds_pkg::KIND_LAYER
         |-> rsp_layer_number != 2'd0 && rsp_sprite_prio_low == 3'd0
             && rsp_sprite_prio_high == 3'd0 && !rsp_run_last
             && rsp_span_end_line != 8'd0)
      else $error("malformed layer transaction");

endmodule

bind layer_priority_draw_sequencer_core lpds_checker u_lpds_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_bus.valid),
   .req_ready            (req_bus.ready),
   .req_last_slice       (req_bus.last_slice),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_command_kind     (rsp_bus.command_kind),
   .rsp_layer_number     (rsp_bus.layer_number),
   .rsp_slice_number     (rsp_bus.slice_number),
   .rsp_span_first_line  (rsp_bus.span_first_line),
   .rsp_span_end_line    (rsp_bus.span_end_line),
   .rsp_sprite_prio_low  (rsp_bus.sprite_prio_low),
   .rsp_sprite_prio_high (rsp_bus.sprite_prio_high),
   .rsp_run_last         (rsp_bus.run_last)
);

[tb/sv/tb_layer_priority_draw_sequencer_core.sv]
`timescale 1ns / 1ps
// Testbench: slice stimulus, draw command prediction and checking for the sequencer core
module tb_layer_priority_draw_sequencer_core;

   localparam int SLICE_SLOTS   = 8;
   localparam int SCREEN_LINES  = 224;
   localparam int PRIO_NONE     = 9999;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 600;
   localparam int PHASE_ITEMS   = 40;

   typedef struct packed {
      logic [15:0] control;
      logic [15:0] prio_word;
      logic [7:0]  start_line;
      logic        last;
   } slice_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] layer;
      logic [3:0] slice;
      logic [7:0] first_line;
      logic [7:0] end_line;
      logic [2:0] prio_low;
      logic [2:0] prio_high;
      logic       run_last;
   } draw_cmd_type;

   // Predict the command stream of each frame and compare it with the block's output
   class draw_cmd_checker;
      logic [15:0]  scroll_mask [1:3];
      logic [3:0]   user_mask;
      logic [2:0]   order_q [SLICE_SLOTS][4];
      logic [2:0]   prio_q [SLICE_SLOTS][1:3];
      logic [3:0]   enables_q [SLICE_SLOTS];
      logic [7:0]   lines_q [SLICE_SLOTS];
      int           stored;
      draw_cmd_type predicted_cmds [$];
      int           errors;

      function new();
         for (int l = 1; l <= 3; l++) scroll_mask[l] = '0;
         user_mask = lpds_pkg::USER_MASK_RESET;
         stored    = 0;
         errors    = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] value);
         case (idx)
            lpds_pkg::REG_SCROLL1_MASK: scroll_mask[1] = value;
            lpds_pkg::REG_SCROLL2_MASK: scroll_mask[2] = value;
            lpds_pkg::REG_SCROLL3_MASK: scroll_mask[3] = value;
            lpds_pkg::REG_USER_MASK:    user_mask = value[3:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return predicted_cmds.size();
      endfunction

      function void push_cmd(logic [1:0] kind, logic [1:0] layer, logic [3:0] slice,
                             logic [7:0] first_line, logic [7:0] end_line,
                             logic [2:0] lo, logic [2:0] hi, logic run_last);
         draw_cmd_type c;
         c = '{kind, layer, slice, first_line, end_line, lo, hi, run_last};
         predicted_cmds.push_back(c);
      endfunction

      // Store one slice; on the last slice of a frame, walk priorities, slices and slots
      function void note_slice(slice_type sl);
         int         slot [4];
         int         pr [4];
         int         high;
         int         lv;
         int         lp;
         int         prev;
         int         span_end;
         logic [3:0] en;
         bit         sprites;
         if (stored < SLICE_SLOTS) begin
            en = 4'b0001;
            for (int l = 1; l <= 3; l++)
               if ((sl.control & scroll_mask[l]) != 0) en[l] = 1'b1;
            en &= user_mask;
            slot[3] = int'(sl.control[13:12]);
            slot[2] = int'(sl.control[11:10]);
            slot[1] = int'(sl.control[9:8]);
            slot[0] = int'(sl.control[7:6]);
            pr[0] = 0;
            pr[1] = int'(sl.prio_word[6:4]);
            pr[2] = int'(sl.prio_word[10:8]);
            pr[3] = int'(sl.prio_word[14:12]);
            // drop a lower duplicate of a layer already placed above it
            for (int b = 2; b >= 0; b--)
               for (int a = 3; a > b; a--)
                  if (slot[a] == slot[b]) slot[b] = -1;
            // clamp lower layers to the priority of the layers drawn above them
            high = PRIO_NONE;
            for (int i = 3; i >= 0; i--) begin
               if (slot[i] > 0) begin
                  if (pr[slot[i]] > high) pr[slot[i]] = high;
                  else high = pr[slot[i]];
               end
            end
            for (int i = 0; i < 4; i++)
               order_q[stored][i] = (slot[i] < 0) ? lpds_pkg::SLOT_GONE : 3'(slot[i]);
            for (int l = 1; l <= 3; l++) prio_q[stored][l] = 3'(pr[l]);
            enables_q[stored] = en;
            lines_q[stored]   = sl.start_line;
            stored++;
         end
         if (!sl.last) return;

         sprites = enables_q[0][0];
         prev    = -1;
         for (int p = 0; p < 8; p++) begin
            for (int s = 0; s < stored; s++) begin
               for (int i = 0; i < 4; i++) begin
                  if (order_q[s][i] == lpds_pkg::SLOT_GONE) continue;
                  lv = int'(order_q[s][i]);
                  lp = (lv == 0) ? 0 : int'(prio_q[s][lv]);
                  if (lp != p) continue;
                  if (sprites && prev < p) begin
                     push_cmd(lpds_pkg::KIND_SPRITE, 2'd0, 4'd0, 8'd0, 8'd0, 3'(prev + 1),
                              3'(p), 1'b0);
                     prev = p;
                  end
                  if (lv > 0 && enables_q[s][lv]) begin
                     span_end = SCREEN_LINES;
                     if (s + 1 < stored && lines_q[s + 1] != 0) span_end = lines_q[s + 1];
                     push_cmd(lpds_pkg::KIND_LAYER, 2'(lv), 4'(s), lines_q[s], 8'(span_end),
                              3'd0, 3'd0, 1'b0);
                  end
               end
            end
         end
         if (sprites && prev < 7)
            push_cmd(lpds_pkg::KIND_SPRITE, 2'd0, 4'd0, 8'd0, 8'd0, 3'(prev + 1),
                     lpds_pkg::PRIO_TOP, 1'b0);
         push_cmd(lpds_pkg::KIND_DONE, 2'd0, 4'd0, 8'd0, 8'd0, 3'd0, 3'd0, 1'b1);
         stored = 0;
      endfunction

      function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
         if (exp_v != act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_cmd(draw_cmd_type got);
         draw_cmd_type exp_c;
         if (predicted_cmds.size() == 0) begin
            $error("command_kind: expected none, actual %0d", got.kind);
            errors++;
            return;
         end
         exp_c = predicted_cmds.pop_front();
         cmp_field("command_kind", exp_c.kind, got.kind);
         cmp_field("layer_number", exp_c.layer, got.layer);
         cmp_field("slice_number", exp_c.slice, got.slice);
         cmp_field("span_first_line", exp_c.first_line, got.first_line);
         cmp_field("span_end_line", exp_c.end_line, got.end_line);
         cmp_field("sprite_prio_low", exp_c.prio_low, got.prio_low);
         cmp_field("sprite_prio_high", exp_c.prio_high, got.prio_high);
         cmp_field("run_last", exp_c.run_last, got.run_last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   lpds_req_if req_bus ();
   lpds_rsp_if rsp_bus ();
   lpds_csr_if csr_bus ();

   layer_priority_draw_sequencer_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   draw_cmd_checker board = new();

   bit no_gaps      = 1'b0;
   bit hold_request = 1'b0;
   int burst_left   = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offer one slice, wait for its transaction, then idle between bursts
   task automatic send_slice(input logic [15:0] ctl, input logic [15:0] pw,
                             input logic [7:0] line, input logic last);
      slice_type sl;
      int        gap;
      sl = '{ctl, pw, line, last};
      req_bus.valid            <= 1'b1;
      req_bus.layer_control    <= ctl;
      req_bus.layer_priority   <= pw;
      req_bus.slice_start_line <= line;
      req_bus.last_slice       <= last;
      do @(posedge clock); while (!req_bus.ready);
      board.note_slice(sl);
      if (!no_gaps) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(1, 12);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Write all four registers back to back
   task automatic load_config(input logic [15:0] m1, input logic [15:0] m2,
                              input logic [15:0] m3, input logic [3:0] um);
      logic [1:0]  reg_idx [4];
      logic [15:0] reg_val [4];
      reg_idx = '{lpds_pkg::REG_SCROLL1_MASK, lpds_pkg::REG_SCROLL2_MASK,
                  lpds_pkg::REG_SCROLL3_MASK, lpds_pkg::REG_USER_MASK};
      reg_val = '{m1, m2, m3, {12'd0, um}};
      for (int i = 0; i < 4; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= reg_idx[i];
         csr_bus.data  <= reg_val[i];
         do @(posedge clock); while (!csr_bus.ready);
         board.set_reg(reg_idx[i], reg_val[i]);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // Hold off until every predicted command has arrived and the walk has settled
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_mask();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'(1 << $urandom_range(0, 15));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Send one frame: mostly full layer permutations, now and then an overfull frame
   task automatic random_frame(inout int count);
      int          len;
      int          perm [4];
      int          j;
      int          k;
      int          tmp;
      logic [15:0] ctl;
      logic [7:0]  line;
      bit          rising;
      len    = ($urandom_range(0, 99) < 85) ? $urandom_range(1, SLICE_SLOTS)
                                            : $urandom_range(SLICE_SLOTS + 1, 12);
      rising = $urandom_range(0, 1);
      line   = 8'($urandom_range(0, 40));
      for (j = 0; j < len; j++) begin
         ctl = 16'($urandom_range(0, 65535));
         if ($urandom_range(0, 99) < 60) begin
            perm = '{0, 1, 2, 3};
            for (k = 3; k > 0; k--) begin
               tmp = $urandom_range(0, k);
               {perm[k], perm[tmp]} = {perm[tmp], perm[k]};
            end
            ctl[13:12] = 2'(perm[3]);
            ctl[11:10] = 2'(perm[2]);
            ctl[9:8]   = 2'(perm[1]);
            ctl[7:6]   = 2'(perm[0]);
         end
         if (!rising) line = 8'($urandom_range(0, 255));
         else if (j > 0) line = 8'(line + $urandom_range(1, 30));
         send_slice(ctl, 16'($urandom_range(0, 65535)), line, j == len - 1);
      end
      count += len;
   endtask

   // Drain the command channel on a stall pattern of its own
   initial begin : result_sink
      draw_cmd_type got;
      int           win;
      int           mode;
      int           hold_left;
      bit           nxt;
      win       = 0;
      mode      = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.command_kind, rsp_bus.layer_number, rsp_bus.slice_number,
                    rsp_bus.span_first_line, rsp_bus.span_end_line, rsp_bus.sprite_prio_low,
                    rsp_bus.sprite_prio_high, rsp_bus.run_last};
            board.check_cmd(got);
         end
         if (win == 0) begin
            win  = $urandom_range(20, 80);
            mode = $urandom_range(0, 3);
         end
         win--;
         if (hold_left > 0) begin
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         case (mode)
            0:       nxt = 1'b1;
            1:       nxt = $urandom_range(0, 1);
            2:       nxt = ($urandom_range(0, 7) != 0);
            default: nxt = ((win % 8) < 5);
         endcase
         rsp_bus.ready <= (hold_left == 0) && nxt;
      end
   end

   initial begin : stimulus
      int phase_items;
      reset                    <= 1'b1;
      req_bus.valid            <= 1'b0;
      req_bus.layer_control    <= '0;
      req_bus.layer_priority   <= '0;
      req_bus.slice_start_line <= '0;
      req_bus.last_slice       <= 1'b0;
      csr_bus.valid            <= 1'b0;
      csr_bus.index            <= lpds_pkg::REG_SCROLL1_MASK;
      csr_bus.data             <= '0;
      rsp_bus.ready            <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: no scroll layer enabled, sprites only
      send_slice(16'h3900, 16'h7520, 8'd0, 1'b1);
      drain_results();

      // every layer enabled: plain order, clamped priorities, duplicates
      load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
      send_slice(16'h3900, 16'h7520, 8'd0, 1'b1);
      send_slice(16'h3900, 16'h1670, 8'd0, 1'b1);
      send_slice(16'hFFFF, 16'hFFFF, 8'd255, 1'b1);
      // several slices with their line spans
      send_slice(16'h0E40, 16'h0000, 8'd0, 1'b0);
      send_slice(16'h2700, 16'h3150, 8'd80, 1'b0);
      send_slice(16'h3900, 16'h7777, 8'd160, 1'b1);
      // next slice starting at line zero closes the span at screen end
      send_slice(16'h3900, 16'h2460, 8'd50, 1'b0);
      send_slice(16'h1B00, 16'h5310, 8'd0, 1'b1);
      // overfull frame: slices past the store are dropped
      for (int j = 0; j < 10; j++)
         send_slice((j % 2 == 0) ? 16'h3900 : 16'h1B00, 16'(j * 16'h1111), 8'(j * 20),
                    j == 9);
      drain_results();

      // sprites and all layers off by the user mask
      load_config(16'h0001, 16'h8000, 16'h0000, 4'h0);
      send_slice(16'h9B01, 16'h6420, 8'd10, 1'b1);
      drain_results();

      // sprites off, layers 1 and 3 allowed; a slice without enable bits draws nothing
      load_config(16'h0001, 16'h8000, 16'h0000, 4'hA);
      send_slice(16'h9B01, 16'h6420, 8'd10, 1'b0);
      send_slice(16'h1B00, 16'h3510, 8'd100, 1'b1);

      // random frames over several settings
      for (int ph = 0; ph < 5; ph++) begin
         drain_results();
         if (ph == 0) load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
         else load_config(pick_mask(), pick_mask(), pick_mask(), 4'($urandom_range(0, 15)));
         no_gaps = (ph == 0);
         if (ph == 2) hold_request = 1'b1;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) random_frame(phase_items);
      end

      drain_results();
      if (board.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Abandon a run that hangs
   initial begin : watchdog
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
